// ===== design/vadd_pkg.sv =====
// Shared types and constants for the vertex attribute dedup unit.
package vadd_pkg;

   localparam int IDX_FIELD_W = 20;
   localparam int OUT_IDX_W   = 10;
   localparam int KEY_MAX_W   = 63;
   localparam int SLOT_MAX_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int HASH_SHIFT  = 29;
   localparam int MUL_SPLIT   = 23;
   localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

   // One classified corner handed from the hash front to the probe engine.
   typedef struct packed {
      logic [KEY_MAX_W-1:0]  key;
      logic [SLOT_MAX_W-1:0] slot;
      logic                  last;
      logic                  mesh;
   } vadd_job_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_EMIT
   } vadd_state_type;

endpackage

// ===== design/vadd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vadd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/vadd_queue.sv =====
// Small register FIFO between the hash front and the probe engine.
module vadd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  vadd_pkg::vadd_job_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output vadd_pkg::vadd_job_type pop_data
);
   import vadd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vadd_job_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/vadd_front.sv =====
// Input stage: packs the corner key and computes its home slot.
module vadd_front #(
   parameter int INDEX_BITS = 20,
   parameter int SLOT_BITS  = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,   // position, texcoord, normal (20 b each), pad
   input  logic                   req_tlast,
   input  logic [0:0]             req_tuser,   // new_mesh
   output logic                   job_valid,
   input  logic                   job_ready,
   output vadd_pkg::vadd_job_type job
);
   import vadd_pkg::*;

   localparam int KEY_W      = 3 * INDEX_BITS;
   localparam int FIELD_KEEP = (INDEX_BITS < IDX_FIELD_W) ? INDEX_BITS : IDX_FIELD_W;
   localparam int PROD_W     = 2 * MUL_SPLIT;
   localparam logic [MUL_SPLIT-1:0] MULT_LO = HASH_MULT[MUL_SPLIT-1:0];
   localparam logic [MUL_SPLIT-1:0] MULT_HI = HASH_MULT[2*MUL_SPLIT-1:MUL_SPLIT];

   logic [KEY_W-1:0]     key;
   logic [63:0]          key_wide;
   logic [MUL_SPLIT-1:0] key_lo, key_hi;
   logic [PROD_W-1:0]    prod_ll, prod_lh, prod_hl;

   logic                 valid_ff, valid_in;
   logic [PROD_W-1:0]    p_ll_ff;
   logic [MUL_SPLIT-1:0] p_lh_ff, p_hl_ff;
   logic [KEY_W-1:0]     key_ff;
   logic                 last_ff, mesh_ff;

   logic [MUL_SPLIT-1:0] cross_sum;
   logic [PROD_W-1:0]    hash;
   logic [SLOT_BITS-1:0] home;
   logic                 load;

   // Each index is cut to INDEX_BITS and placed on an INDEX_BITS grid.
   always_comb begin
      key = '0;
      key[FIELD_KEEP-1:0]                = req_tdata[FIELD_KEEP-1:0];
      key[INDEX_BITS +: FIELD_KEEP]      = req_tdata[IDX_FIELD_W +: FIELD_KEEP];
      key[2*INDEX_BITS +: FIELD_KEEP]    = req_tdata[2*IDX_FIELD_W +: FIELD_KEEP];
   end

   assign key_wide = 64'(key);
   assign key_lo   = key_wide[MUL_SPLIT-1:0];
   assign key_hi   = key_wide[2*MUL_SPLIT-1:MUL_SPLIT];

   // Only the low 46 bits of the 64-bit product reach the slot bits.
   assign prod_ll = PROD_W'(key_lo) * PROD_W'(MULT_LO);
   assign prod_lh = PROD_W'(key_lo) * PROD_W'(MULT_HI);
   assign prod_hl = PROD_W'(key_hi) * PROD_W'(MULT_LO);

   assign req_tready = !valid_ff || job_ready;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         p_ll_ff <= prod_ll;
         p_lh_ff <= prod_lh[MUL_SPLIT-1:0];
         p_hl_ff <= prod_hl[MUL_SPLIT-1:0];
         key_ff  <= key;
         last_ff <= req_tlast;
         mesh_ff <= req_tuser[0];
      end
   end

   assign cross_sum = p_lh_ff + p_hl_ff;
   assign hash      = p_ll_ff + {cross_sum, {MUL_SPLIT{1'b0}}};
   assign home      = hash[SLOT_BITS-1:0] ^ hash[HASH_SHIFT +: SLOT_BITS];

   assign job_valid = valid_ff;
   always_comb begin
      job      = '0;
      job.key  = KEY_MAX_W'(key_ff);
      job.slot = SLOT_MAX_W'(home);
      job.last = last_ff;
      job.mesh = mesh_ff;
   end

endmodule

// ===== design/vadd_back.sv =====
// Probe engine: table clear sweep, linear probing, insert and result register.
module vadd_back #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int INDEX_BITS    = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  vadd_pkg::vadd_job_type job,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [vadd_pkg::OUT_IDX_W-1:0] rsp_index,
   output logic                   rsp_tlast,
   output logic                   rsp_first,
   output logic                   rsp_overflow
);
   import vadd_pkg::*;

   localparam int SB        = $clog2(TABLE_ENTRIES);
   localparam int KEY_W     = 3 * INDEX_BITS;
   localparam int ENTRY_W   = 1 + SB + KEY_W;
   localparam int OUT_EXT_W = (SB > OUT_IDX_W) ? SB : OUT_IDX_W;
   localparam logic [SB:0]   NF_FULL   = (SB+1)'(TABLE_ENTRIES);
   localparam logic [SB-1:0] LAST_SLOT = SB'(TABLE_ENTRIES - 1);

   vadd_state_type state_ff, state_in;
   logic [SB-1:0]  clr_ff, clr_in;
   logic           pend_ff, pend_in;
   logic [SB:0]    nf_ff, nf_in;
   logic [SB-1:0]  slot_ff, slot_in;
   logic [SB-1:0]  probe_ff, probe_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic           last_ff, last_in;
   logic [SB-1:0]  res_idx_ff, res_idx_in;
   logic           res_first_ff, res_first_in;
   logic           res_ovf_ff, res_ovf_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_first_ff, rsp_first_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic               wr_en;
   logic [SB-1:0]      wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic               rd_valid;
   logic [SB-1:0]      rd_value;
   logic [KEY_W-1:0]   rd_key;
   logic [SB-1:0]      slot_next;
   logic [OUT_EXT_W-1:0] res_ext;

   vadd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_valid  = rd_data[ENTRY_W-1];
   assign rd_value  = rd_data[KEY_W +: SB];
   assign rd_key    = rd_data[KEY_W-1:0];
   assign slot_next = slot_ff + SB'(1);
   assign res_ext   = OUT_EXT_W'(res_idx_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      nf_in        = nf_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      res_idx_in   = res_idx_ff;
      res_first_in = res_first_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_first_in = rsp_first_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      job_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = '0;
      rd_addr      = slot_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + SB'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = pend_ff ? ST_PROBE : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               key_in   = job.key[KEY_W-1:0];
               slot_in  = job.slot[SB-1:0];
               last_in  = job.last;
               probe_in = '0;
               if (job.mesh) begin
                  // empty the table first, then probe for this corner
                  nf_in    = '0;
                  clr_in   = '0;
                  pend_in  = 1'b1;
                  state_in = ST_CLEAR;
               end else begin
                  rd_addr  = job.slot[SB-1:0];
                  state_in = ST_CHECK;
               end
            end
         end
         ST_PROBE: begin
            rd_addr  = slot_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!rd_valid) begin
               if (nf_ff < NF_FULL) begin
                  wr_en        = 1'b1;
                  wr_data      = {1'b1, nf_ff[SB-1:0], key_ff};
                  res_idx_in   = nf_ff[SB-1:0];
                  res_first_in = 1'b1;
                  res_ovf_in   = 1'b0;
                  nf_in        = nf_ff + (SB+1)'(1);
               end else begin
                  res_idx_in   = '0;
                  res_first_in = 1'b0;
                  res_ovf_in   = 1'b1;
               end
               state_in = ST_EMIT;
            end else if (rd_key == key_ff) begin
               res_idx_in   = rd_value;
               res_first_in = 1'b0;
               res_ovf_in   = 1'b0;
               state_in     = ST_EMIT;
            end else if (probe_ff == LAST_SLOT) begin
               // whole table walked, every slot taken
               res_idx_in   = '0;
               res_first_in = 1'b0;
               res_ovf_in   = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               rd_addr  = slot_next;
               slot_in  = slot_next;
               probe_in = probe_ff + SB'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = res_ext[OUT_IDX_W-1:0];
               rsp_last_in  = last_ff;
               rsp_first_in = res_first_ff;
               rsp_ovf_in   = res_ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         nf_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         nf_ff        <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff      <= slot_in;
      probe_ff     <= probe_in;
      key_ff       <= key_in;
      last_ff      <= last_in;
      res_idx_ff   <= res_idx_in;
      res_first_ff <= res_first_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_first_ff <= rsp_first_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_index    = rsp_idx_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_first    = rsp_first_ff;
   assign rsp_overflow = rsp_ovf_ff;

   a_nf_bound: assert property (@(posedge clock) disable iff (reset)
      nf_ff <= NF_FULL)
      else $error("next free index beyond table size");

   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_first_ff && rsp_ovf_ff))
      else $error("item marked both new and overflow");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && wr_en) |=> (nf_ff == $past(nf_ff) + (SB+1)'(1)))
      else $error("insert did not advance next free index");

   a_insert_valid: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != ST_CLEAR) |-> wr_data[ENTRY_W-1])
      else $error("table write outside clear without valid bit");

   a_reset_clear: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == ST_CLEAR && clr_ff == '0))
      else $error("clear sweep not started after reset");

endmodule

// ===== design/vertex_attribute_dedup_unit.sv =====
// Top level of the vertex attribute dedup unit.
//
// Input channel req_*: one face corner per item. req_tdata carries the position,
// texcoord and normal indices, req_tlast marks the polygon's last corner and
// req_tuser[0] starts a new mesh (the table is emptied before that corner).
// Result channel rsp_*: one item per corner, in order. rsp_tdata holds the dense
// vertex index, rsp_tuser flags a first-seen triple and a table overflow,
// rsp_tlast copies the polygon mark.
// Flow: the front hashes a corner in a registered multiply stage and passes it
// through a two-entry queue. The probe engine takes one corner at a time: it reads
// table slots by linear probe, starting at the home slot, through the table RAM's
// single read port, and loads the result register before it takes the next corner.
// After reset, and for each corner with the new-mesh flag, the engine sweeps every
// table slot to clear it; no corner is probed meanwhile, but the front and queue
// keep accepting until full.
// A stalled receiver holds the result register; the engine finishes the next
// corner and waits, and the front backs up through the queue to req_tready.
// TABLE_ENTRIES must be a power of two.
module vertex_attribute_dedup_unit #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int INDEX_BITS    = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pos_idx[19:0], uv_idx[39:20],
                                    // nrm_idx[59:40], zero pad
   input  logic        req_tlast,   // polygon_end
   input  logic [0:0]  req_tuser,   // new_mesh
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // output_index[9:0], zero pad
   output logic        rsp_tlast,   // polygon_last
   output logic [1:0]  rsp_tuser    // first_seen[0], overflow[1]
);
   import vadd_pkg::*;

   localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);

   logic                 front_valid, front_ready;
   vadd_job_type         front_job;
   logic                 back_valid, back_ready;
   vadd_job_type         back_job;
   logic [OUT_IDX_W-1:0] rsp_index;
   logic                 rsp_first, rsp_overflow;

   vadd_front #(
      .INDEX_BITS (INDEX_BITS),
      .SLOT_BITS  (SLOT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .job_valid  (front_valid),
      .job_ready  (front_ready),
      .job        (front_job)
   );

   vadd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   vadd_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .INDEX_BITS    (INDEX_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (back_valid),
      .job_ready    (back_ready),
      .job          (back_job),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_index    (rsp_index),
      .rsp_tlast    (rsp_tlast),
      .rsp_first    (rsp_first),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tdata = {{(16 - OUT_IDX_W){1'b0}}, rsp_index};
   assign rsp_tuser = {rsp_overflow, rsp_first};

endmodule

// ===== tb/sv/dedup_tb_pkg.sv =====
`timescale 1ns / 100ps
// Item types and the vertex-index scoreboard for the dedup unit testbench.
package dedup_tb_pkg;
   import vadd_pkg::*;

   localparam int TABLE_ENTRIES = 1024;
   localparam int INDEX_BITS    = 20;

   typedef logic [IDX_FIELD_W-1:0]   idx_type;
   typedef logic [3*IDX_FIELD_W-1:0] triple_key_type;

   typedef struct packed {
      idx_type pos;
      idx_type tex;
      idx_type nrm;
      logic    poly_end;
      logic    new_mesh;
   } corner_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] vtx;
      logic                 first_seen;
      logic                 poly_last;
      logic                 overflow;
   } vertex_ref_type;

   class dedup_scoreboard;
      int unsigned    vtx_of_key[triple_key_type];
      int unsigned    next_vtx;
      vertex_ref_type expected_vtx[$];   // newest at the front, oldest at the back
      int             mismatches;

      function new();
         next_vtx   = 0;
         mismatches = 0;
      endfunction

      // Accepted corner: assign its dense index the way the unit should.
      function void note_corner(corner_type c);
         idx_type        mask;
         triple_key_type key;
         logic [31:0]    v;
         vertex_ref_type r;
         mask = '1;
         mask = mask >> (IDX_FIELD_W - INDEX_BITS);
         key  = {c.nrm & mask, c.tex & mask, c.pos & mask};
         if (c.new_mesh) begin
            vtx_of_key.delete();
            next_vtx = 0;
         end
         r           = '0;
         r.poly_last = c.poly_end;
         if (vtx_of_key.exists(key)) begin
            v     = vtx_of_key[key];
            r.vtx = v[OUT_IDX_W-1:0];
         end else if (next_vtx < TABLE_ENTRIES) begin
            vtx_of_key[key] = next_vtx;
            v            = next_vtx;
            r.vtx        = v[OUT_IDX_W-1:0];
            r.first_seen = 1'b1;
            next_vtx++;
         end else begin
            r.overflow = 1'b1;   // table full, triple not stored
         end
         expected_vtx.push_front(r);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_result(logic [15:0] data, logic last, logic [1:0] user);
         vertex_ref_type got;
         vertex_ref_type want;
         got = {data[OUT_IDX_W-1:0], user[0], last, user[1]};
         if (expected_vtx.size() == 0) begin
            report_mismatch($sformatf("unexpected item idx=%0d new=%0b last=%0b ovf=%0b",
                                      got.vtx, got.first_seen, got.poly_last, got.overflow));
            return;
         end
         want = expected_vtx.pop_back();
         if (got !== want)
            report_mismatch($sformatf("idx=%0d new=%0b last=%0b ovf=%0b, want %0d/%0b/%0b/%0b",
                                      got.vtx, got.first_seen, got.poly_last, got.overflow,
                                      want.vtx, want.first_seen, want.poly_last,
                                      want.overflow));
         if (data[15:OUT_IDX_W] !== '0)
            report_mismatch($sformatf("tdata pad bits set: %h", data));
      endtask

      function int pending();
         return expected_vtx.size();
      endfunction

      function int unsigned vertices();
         return next_vtx;
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top-level testbench: drives face corners into the dedup unit and checks indices.
module tb_top;
   import vadd_pkg::*;
   import dedup_tb_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 90;
   localparam int SETTLE_CYCLES = TABLE_ENTRIES + 64;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   dedup_scoreboard sb = new();
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bit          burst          = 1'b0;
   bit          hold_request   = 1'b0;
   int unsigned sent           = 0;
   corner_type  recent[$];

   always #4 clock = ~clock;

   vertex_attribute_dedup_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .INDEX_BITS   (INDEX_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      #12_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Result side: check accepted items, then pick next cycle's tready.
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic idx_type rand_idx();
      int unsigned r;
      r = $urandom();
      return r[IDX_FIELD_W-1:0];
   endfunction

   function automatic corner_type mk(idx_type p, idx_type t, idx_type n, logic last,
                                     logic mesh);
      corner_type c;
      c = {p, t, n, last, mesh};
      return c;
   endfunction

   function automatic corner_type random_corner();
      return mk(rand_idx(), rand_idx(), rand_idx(), 1'b0, 1'b0);
   endfunction

   task automatic send_corner(input corner_type c);
      while (!burst && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(64 - 3*IDX_FIELD_W){1'b0}}, c.nrm, c.tex, c.pos};
      req_tlast  <= c.poly_end;
      req_tuser  <= c.new_mesh;
      do @(posedge clock); while (!req_tready);
      sb.note_corner(c);
      sent++;
      case ((sent / PHASE_ITEMS) % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
         default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Polygons of 1..5 corners with heavy reuse of recent triples, some near misses
   // (one field shared with a known triple) and an occasional new mesh.
   task automatic run_meshes(int count);
      corner_type c;
      int         left_in_poly;
      int         roll;
      left_in_poly = $urandom_range(5, 3);
      repeat (count) begin
         roll = $urandom_range(99);
         if (recent.size() > 0 && roll < 55) begin
            c = recent[$urandom_range(recent.size() - 1)];
         end else begin
            c = random_corner();
            if (recent.size() > 0 && roll < 65)
               c.tex = recent[$urandom_range(recent.size() - 1)].tex;
            recent.push_front(c);
            if (recent.size() > 48) void'(recent.pop_back());
         end
         c.new_mesh = ($urandom_range(39) == 0);
         if (c.new_mesh) begin
            recent.delete();
            recent.push_front(c);
         end
         left_in_poly--;
         c.poly_end = (left_in_poly <= 0) || ($urandom_range(19) == 0);
         if (c.poly_end) left_in_poly = $urandom_range(5, 3);
         send_corner(c);
      end
   endtask

   // One mesh filled to the last slot, then new triples overflow while stored
   // triples are still found.
   task automatic fill_then_overflow();
      corner_type c;
      corner_type stored[$];
      c = random_corner();
      c.new_mesh = 1'b1;
      stored.push_front(c);
      send_corner(c);
      while (sb.vertices() < TABLE_ENTRIES) begin
         if ($urandom_range(19) == 0) begin
            c = stored[$urandom_range(stored.size() - 1)];
         end else begin
            c = random_corner();
            stored.push_front(c);
         end
         c.new_mesh = 1'b0;
         c.poly_end = ($urandom_range(2) == 0);
         send_corner(c);
      end
      repeat (36) begin
         if ($urandom_range(1) == 1)
            c = random_corner();
         else
            c = stored[$urandom_range(stored.size() - 1)];
         c.new_mesh = 1'b0;
         c.poly_end = ($urandom_range(1) == 1);
         send_corner(c);
      end
   endtask

   initial begin : stimulus
      @(posedge clock);
      @(posedge clock);
      reset <= 1'b0;

      // extremes, reuse, single-field differences, and clears
      send_corner(mk('0, '0, '0, 1'b0, 1'b1));
      send_corner(mk('1, '1, '1, 1'b0, 1'b0));
      send_corner(mk('0, '0, '0, 1'b0, 1'b0));
      send_corner(mk('1, '0, '0, 1'b0, 1'b0));
      send_corner(mk('0, '1, '0, 1'b0, 1'b0));
      send_corner(mk('0, '0, '1, 1'b1, 1'b0));
      send_corner(mk('1, '1, '1, 1'b1, 1'b0));
      send_corner(mk(20'h55555, 20'hAAAAA, 20'h55555, 1'b0, 1'b0));
      send_corner(mk(20'hAAAAA, 20'h55555, 20'hAAAAA, 1'b1, 1'b0));
      send_corner(mk('1, '1, '1, 1'b0, 1'b1));
      send_corner(mk('1, '1, '1, 1'b0, 1'b1));
      send_corner(mk('0, '0, '0, 1'b1, 1'b0));
      send_corner(mk(20'h12345, 20'hFEDCB, 20'h0F0F0, 1'b1, 1'b1));
      send_corner(mk(20'h12345, 20'hFEDCB, 20'h0F0F0, 1'b0, 1'b0));

      run_meshes(150);

      // receiver holds off while the sender keeps offering, backing up the unit
      burst        = 1'b1;
      hold_request = 1'b1;
      run_meshes(16);
      burst = 1'b0;
      wait_drained();

      run_meshes(50);
      fill_then_overflow();
      send_corner(mk('1, '0, '1, 1'b0, 1'b1));   // recovery from a full table
      run_meshes(40);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
